// ----- hw/rtl/assert_macros.svh -----
// assertion macros shared by the lca engine rtl
// expects clk_i and rst_ni in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define PT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define PT_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define PT_ASSERT(lbl, prop, msg)
`define PT_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ----- hw/rtl/ptlca_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants of the parent table lca engine
// used by every module of the block, no dependencies
package ptlca_pkg;

  localparam int unsigned ID_BITS     = 16;
  localparam int unsigned NODE_COUNT  = 65536;
  localparam int unsigned ADDR_BITS   = $clog2(NODE_COUNT);
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_BITS   = $clog2(QUEUE_DEPTH);

  typedef logic [ID_BITS-1:0] id_t;

  localparam id_t ROOT_ID = id_t'(1);

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_ANC   = 2'd1,
    ACT_PAIR  = 2'd2,
    ACT_LIST  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_ANC,
    OP_PAIR,
    OP_LIST
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_CHECK,
    ST_RESULT
  } state_e;

  typedef struct packed {
    op_e  op;
    id_t  node_a;
    id_t  node_b;
    logic first;
    logic last;
    logic a_zero;
    logic b_zero;
  } cmd_t;

endpackage

// ----- hw/rtl/parent_table_lca_engine.sv -----
`timescale 1ns / 1ps
// Parent table LCA engine. Requests are classified at the front and pass a
// four-entry command queue to the climb engine, so requests keep being taken
// while the engine climbs or a result waits on out_stall_i, until the queue
// fills. A parent write gives no result. Ancestor tests, pair LCAs and list
// elements climb the 65536 x 16 parent table with its registered read (one
// parent read, then one compare, per step); an ancestor test or pair LCA with
// a zero id does not climb. A result is loaded into the output register once
// that register is free of a stalled result.
// The table is not cleared at reset and must be written before it is climbed.
// Only a list element marked last produces a result; the running list state
// holds until the next first element.
// Depends on ptlca_pkg, ptlca_front, ptlca_fifo and ptlca_back.
module parent_table_lca_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [15:0] node_a_i,
  input  logic [15:0] node_b_i,
  input  logic        first_of_list_i,
  input  logic        last_of_list_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] result_node_o,
  output logic        is_ancestor_o,
  output logic        error_o
);

  ptlca_pkg::cmd_t push_cmd;
  ptlca_pkg::cmd_t head_cmd;
  logic            push;
  logic            pop;
  logic            empty;
  logic            full;

  ptlca_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .action_i        (action_i),
    .node_a_i        (node_a_i),
    .node_b_i        (node_b_i),
    .first_of_list_i (first_of_list_i),
    .last_of_list_i  (last_of_list_i),
    .full_i          (full),
    .push_o          (push),
    .cmd_o           (push_cmd)
  );

  ptlca_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .head_o  (head_cmd),
    .empty_o (empty),
    .full_o  (full)
  );

  ptlca_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head_cmd),
    .empty_i       (empty),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .result_node_o (result_node_o),
    .is_ancestor_o (is_ancestor_o),
    .error_o       (error_o)
  );

endmodule

// ----- hw/rtl/ptlca_front.sv -----
`timescale 1ns / 1ps
// request front end: input handshake and classification into commands
// depends on ptlca_pkg and assert_macros.svh
`include "assert_macros.svh"
module ptlca_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           action_i,
  input  logic [15:0]          node_a_i,
  input  logic [15:0]          node_b_i,
  input  logic                 first_of_list_i,
  input  logic                 last_of_list_i,
  input  logic                 full_i,
  output logic                 push_o,
  output ptlca_pkg::cmd_t      cmd_o
);

  ptlca_pkg::id_t   id_a;
  ptlca_pkg::id_t   id_b;
  ptlca_pkg::op_e   op;
  logic             seen_q;
  logic             seen_d;

  assign id_a = node_a_i[ptlca_pkg::ID_BITS-1:0];
  assign id_b = node_b_i[ptlca_pkg::ID_BITS-1:0];

  always_comb begin
    unique case (ptlca_pkg::action_e'(action_i))
      ptlca_pkg::ACT_WRITE: op = ptlca_pkg::OP_WRITE;
      ptlca_pkg::ACT_ANC:   op = ptlca_pkg::OP_ANC;
      ptlca_pkg::ACT_PAIR:  op = ptlca_pkg::OP_PAIR;
      ptlca_pkg::ACT_LIST:  op = ptlca_pkg::OP_LIST;
      default:              op = ptlca_pkg::OP_WRITE;
    endcase
  end

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    cmd_o.op     = op;
    cmd_o.node_a = id_a;
    cmd_o.node_b = id_b;
    cmd_o.first  = first_of_list_i;
    cmd_o.last   = last_of_list_i;
    cmd_o.a_zero = (id_a == '0);
    cmd_o.b_zero = (id_b == '0);
  end

  // sticky flag that a request has been taken since reset
  assign seen_d = seen_q || push_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
    end else begin
      seen_q <= seen_d;
    end
  end

  `PT_ASSERT_NEVER(a_push_into_full, push_o && full_i, "request pushed into full queue")
  `PT_ASSERT(a_seen_sticky, seen_q |=> seen_q, "request flag dropped")

endmodule

// ----- hw/rtl/ptlca_fifo.sv -----
`timescale 1ns / 1ps
// short command queue between front end and climb engine
// depends on ptlca_pkg and assert_macros.svh
`include "assert_macros.svh"
module ptlca_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ptlca_pkg::cmd_t   cmd_i,
  input  logic              pop_i,
  output ptlca_pkg::cmd_t   head_o,
  output logic              empty_o,
  output logic              full_o
);

  localparam int unsigned CNT_BITS = ptlca_pkg::QPTR_BITS + 1;

  ptlca_pkg::cmd_t                  entry_q [ptlca_pkg::QUEUE_DEPTH];
  logic [ptlca_pkg::QPTR_BITS-1:0]  wr_ptr_q;
  logic [ptlca_pkg::QPTR_BITS-1:0]  wr_ptr_d;
  logic [ptlca_pkg::QPTR_BITS-1:0]  rd_ptr_q;
  logic [ptlca_pkg::QPTR_BITS-1:0]  rd_ptr_d;
  logic [CNT_BITS-1:0]              count_q;
  logic [CNT_BITS-1:0]              count_d;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CNT_BITS'(ptlca_pkg::QUEUE_DEPTH));
  assign head_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

  `PT_ASSERT_NEVER(a_pop_when_empty, pop_i && empty_o, "command popped from empty queue")

endmodule

// ----- hw/rtl/ptlca_back.sv -----
`timescale 1ns / 1ps
// climb engine: parent table memory, climb sequencer and result register
// depends on ptlca_pkg and assert_macros.svh
`include "assert_macros.svh"
module ptlca_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ptlca_pkg::cmd_t   head_i,
  input  logic              empty_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [15:0]       result_node_o,
  output logic              is_ancestor_o,
  output logic              error_o
);

  ptlca_pkg::id_t  table_mem [ptlca_pkg::NODE_COUNT];

  ptlca_pkg::state_e state_q, state_d;
  ptlca_pkg::op_e    mode_q, mode_d;
  ptlca_pkg::id_t    x_q, x_d;
  ptlca_pkg::id_t    y_q, y_d;
  ptlca_pkg::id_t    running_q, running_d;
  logic              lerr_q, lerr_d;
  logic              last_q, last_d;
  logic              climb_y_q, climb_y_d;
  ptlca_pkg::id_t    res_node_q, res_node_d;
  logic              res_anc_q, res_anc_d;
  logic              res_err_q, res_err_d;
  logic              out_valid_q, out_valid_d;
  ptlca_pkg::id_t    out_node_q;
  logic              out_anc_q;
  logic              out_err_q;

  ptlca_pkg::id_t    rdata_q;
  logic              oob_q;
  ptlca_pkg::id_t    rd_id;
  ptlca_pkg::id_t    parent;
  ptlca_pkg::id_t    cur_id;
  logic              mem_we;
  logic              out_load;
  logic              out_free;
  logic              head_zero;
  logic              fold_skip;
  logic              fold_trivial;
  logic              step_done;
  logic              chk_err;
  logic              list_hold;

  assign out_free     = !out_valid_q || !out_stall_i;
  assign head_zero    = head_i.a_zero || head_i.b_zero;
  assign fold_skip    = lerr_q || (running_q == ptlca_pkg::ROOT_ID);
  assign fold_trivial = (running_q == '0) || head_i.a_zero;
  assign step_done    = (mode_q == ptlca_pkg::OP_ANC) ? !(y_q > x_q) : (x_q == y_q);
  assign parent       = oob_q ? '0 : rdata_q;
  assign cur_id       = climb_y_q ? y_q : x_q;
  assign chk_err      = (parent >= cur_id);
  assign list_hold    = (mode_q == ptlca_pkg::OP_LIST) && !last_q;
  assign rd_id        = ((mode_q == ptlca_pkg::OP_ANC) || (y_q > x_q)) ? y_q : x_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ptlca_pkg::ST_IDLE: begin
        if (!empty_i) begin
          unique case (head_i.op)
            ptlca_pkg::OP_WRITE: state_d = ptlca_pkg::ST_IDLE;
            ptlca_pkg::OP_ANC,
            ptlca_pkg::OP_PAIR: begin
              state_d = head_zero ? ptlca_pkg::ST_RESULT : ptlca_pkg::ST_STEP;
            end
            ptlca_pkg::OP_LIST: begin
              if (head_i.first || fold_skip || fold_trivial) begin
                state_d = head_i.last ? ptlca_pkg::ST_RESULT : ptlca_pkg::ST_IDLE;
              end else begin
                state_d = ptlca_pkg::ST_STEP;
              end
            end
            default: state_d = ptlca_pkg::ST_IDLE;
          endcase
        end
      end
      ptlca_pkg::ST_STEP: begin
        if (step_done) begin
          state_d = list_hold ? ptlca_pkg::ST_IDLE : ptlca_pkg::ST_RESULT;
        end else begin
          state_d = ptlca_pkg::ST_CHECK;
        end
      end
      ptlca_pkg::ST_CHECK: begin
        if (chk_err) begin
          state_d = list_hold ? ptlca_pkg::ST_IDLE : ptlca_pkg::ST_RESULT;
        end else begin
          state_d = ptlca_pkg::ST_STEP;
        end
      end
      ptlca_pkg::ST_RESULT: begin
        state_d = out_free ? ptlca_pkg::ST_IDLE : ptlca_pkg::ST_RESULT;
      end
      default: state_d = ptlca_pkg::ST_IDLE;
    endcase
  end

  // datapath and control outputs
  always_comb begin
    pop_o      = 1'b0;
    mem_we     = 1'b0;
    out_load   = 1'b0;
    mode_d     = mode_q;
    x_d        = x_q;
    y_d        = y_q;
    running_d  = running_q;
    lerr_d     = lerr_q;
    last_d     = last_q;
    climb_y_d  = climb_y_q;
    res_node_d = res_node_q;
    res_anc_d  = res_anc_q;
    res_err_d  = res_err_q;
    unique case (state_q)
      ptlca_pkg::ST_IDLE: begin
        if (!empty_i) begin
          pop_o      = 1'b1;
          mode_d     = head_i.op;
          last_d     = head_i.last;
          x_d        = head_i.node_a;
          y_d        = head_i.node_b;
          res_node_d = '0;
          res_anc_d  = 1'b0;
          res_err_d  = 1'b0;
          unique case (head_i.op)
            ptlca_pkg::OP_WRITE: begin
              mem_we = ((head_i.node_a >> ptlca_pkg::ADDR_BITS) == '0);
            end
            ptlca_pkg::OP_ANC: begin
              res_err_d = head_zero;
            end
            ptlca_pkg::OP_PAIR: begin
              if (head_zero) begin
                res_node_d = head_i.a_zero ? head_i.node_b : head_i.node_a;
              end
            end
            ptlca_pkg::OP_LIST: begin
              if (head_i.first) begin
                running_d = head_i.node_a;
                lerr_d    = 1'b0;
              end else if (!fold_skip) begin
                if (fold_trivial) begin
                  running_d = (running_q == '0) ? head_i.node_a : running_q;
                end else begin
                  x_d = running_q;
                  y_d = head_i.node_a;
                end
              end
            end
            default: mem_we = 1'b0;
          endcase
        end
      end
      ptlca_pkg::ST_STEP: begin
        if (step_done) begin
          case (mode_q)
            ptlca_pkg::OP_ANC:  res_anc_d  = (x_q == y_q);
            ptlca_pkg::OP_PAIR: res_node_d = x_q;
            ptlca_pkg::OP_LIST: running_d  = x_q;
            default:            res_node_d = res_node_q;
          endcase
        end else begin
          climb_y_d = (mode_q == ptlca_pkg::OP_ANC) || (y_q > x_q);
        end
      end
      ptlca_pkg::ST_CHECK: begin
        if (chk_err) begin
          if (mode_q == ptlca_pkg::OP_LIST) begin
            lerr_d = 1'b1;
          end else begin
            res_err_d = 1'b1;
          end
        end else if (climb_y_q) begin
          y_d = parent;
        end else begin
          x_d = parent;
        end
      end
      ptlca_pkg::ST_RESULT: begin
        out_load = out_free;
      end
      default: pop_o = 1'b0;
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ptlca_pkg::ST_IDLE;
      running_q   <= '0;
      lerr_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      running_q   <= running_d;
      lerr_q      <= lerr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q     <= mode_d;
    x_q        <= x_d;
    y_q        <= y_d;
    last_q     <= last_d;
    climb_y_q  <= climb_y_d;
    res_node_q <= res_node_d;
    res_anc_q  <= res_anc_d;
    res_err_q  <= res_err_d;
    if (out_load) begin
      if (mode_q == ptlca_pkg::OP_LIST) begin
        out_node_q <= lerr_q ? '0 : running_q;
        out_anc_q  <= 1'b0;
        out_err_q  <= lerr_q;
      end else begin
        out_node_q <= res_node_q;
        out_anc_q  <= res_anc_q;
        out_err_q  <= res_err_q;
      end
    end
  end

  // parent table, one write port and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      table_mem[head_i.node_a[ptlca_pkg::ADDR_BITS-1:0]] <= head_i.node_b;
    end
    rdata_q <= table_mem[rd_id[ptlca_pkg::ADDR_BITS-1:0]];
    oob_q   <= ((rd_id >> ptlca_pkg::ADDR_BITS) != '0);
  end

  assign out_valid_o   = out_valid_q;
  assign result_node_o = 16'(out_node_q);
  assign is_ancestor_o = out_anc_q;
  assign error_o       = out_err_q;

  `PT_ASSERT(a_climb_descends, (state_q == ptlca_pkg::ST_CHECK && !chk_err) |=> (x_q < $past(x_q)) || (y_q < $past(y_q)), "climb step did not descend")
  `PT_ASSERT(a_result_loaded, (state_q == ptlca_pkg::ST_RESULT && out_free) |=> out_valid_q, "result left without output")

endmodule
